/* rtl/iee_pkg.sv */
// ----------------------------------------------------------------------------
// iee_pkg : shared types and constants of the infix expression evaluator
// Operator codes, character classes, status codes, FSM states and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package iee_pkg;

  // Default stack depth for both stacks
  localparam int unsigned IEE_STACK_DEPTH = 64;

  // Operand width and output packing
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned STS_W      = 2;
  localparam int unsigned OUT_DATA_W = ((DATA_W + STS_W + 7) / 8) * 8;
  localparam int unsigned OPC_W      = 3;

  // ASCII codes that mean something to the evaluator
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;

  // Codes held on the operator stack
  typedef enum logic [OPC_W-1:0] {
    OPC_ADD  = 3'd0,
    OPC_SUB  = 3'd1,
    OPC_MUL  = 3'd2,
    OPC_DIV  = 3'd3,
    OPC_LPAR = 3'd4
  } opc_e;

  // Character classes
  typedef enum logic [2:0] {
    CHR_DIGIT,
    CHR_ADDSUB,
    CHR_MULDIV,
    CHR_LPAR,
    CHR_RPAR,
    CHR_OTHER
  } chr_e;

  // Result status codes
  typedef enum logic [STS_W-1:0] {
    STS_OK       = 2'd0,
    STS_DIVZERO  = 2'd1,
    STS_OVERFLOW = 2'd2
  } sts_e;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_RED_RD,
    S_RED_LD,
    S_RED_EXEC,
    S_RED_DIV,
    S_RED_WB,
    S_POP_WAIT,
    S_FINAL,
    S_EMIT
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic       opnd_push;  // push digit onto operand stack
    logic [3:0] digit;
    logic       opr_push;   // push operator code
    opc_e       opr_code;
    logic       opr_pop;    // drop top operator, fetch new top
    logic       top_ld;     // load fetched operator top
    logic       red_rd;     // reduction: pop operator, fetch second operand
    logic       red_ld;     // reduction: latch operands
    logic       red_exec;   // reduction: compute or start divider
    logic       red_wb;     // reduction: push result
    logic       emit;       // load result beat, clear stacks
  } iee_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic opnd_ge2;
    logic opr_empty;
    opc_e opr_top;
    logic red_is_div;
    logic div_done;
    logic out_full;
  } iee_sts_t;

  // Classify one input character
  function automatic chr_e classify(input logic [7:0] sym);
    chr_e c;
    c = CHR_OTHER;
    if (sym >= CH_ZERO && sym <= CH_NINE) begin
      c = CHR_DIGIT;
    end else if (sym == CH_PLUS || sym == CH_MINUS) begin
      c = CHR_ADDSUB;
    end else if (sym == CH_STAR || sym == CH_SLASH) begin
      c = CHR_MULDIV;
    end else if (sym == CH_LPAR) begin
      c = CHR_LPAR;
    end else if (sym == CH_RPAR) begin
      c = CHR_RPAR;
    end
    return c;
  endfunction

endpackage

/* rtl/iee_ram.sv */
// ----------------------------------------------------------------------------
// iee_ram : generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module iee_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/iee_div.sv */
// ----------------------------------------------------------------------------
// iee_div : iterative signed divider
// Restoring division on magnitudes, one quotient bit a cycle, truncating
// toward zero. A zero divisor finishes at once with quotient 0 and a flag.
// ----------------------------------------------------------------------------
module iee_div
  import iee_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] num_i,
  input  logic [DATA_W-1:0] den_i,
  output logic              done_o,
  output logic [DATA_W-1:0] quot_o,
  output logic              dz_o
);

  localparam int unsigned SW = $clog2(DATA_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [SW-1:0]     step_q, step_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] den_q, den_d;
  logic              neg_q, neg_d;
  logic              dz_q, dz_d;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;

  // Shift-subtract step
  assign rem_sh = {rem_q, quo_q[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};

  // Next state
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    dz_d   = dz_q;
    if (start_i) begin
      if (den_i == '0) begin
        done_d = 1'b1;
        quo_d  = '0;
        neg_d  = 1'b0;
        dz_d   = 1'b1;
      end else begin
        busy_d = 1'b1;
        step_d = SW'(DATA_W);
        quo_d  = num_i[DATA_W-1] ? ('0 - num_i) : num_i;
        den_d  = den_i[DATA_W-1] ? ('0 - den_i) : den_i;
        rem_d  = '0;
        neg_d  = num_i[DATA_W-1] ^ den_i[DATA_W-1];
        dz_d   = 1'b0;
      end
    end else if (busy_q) begin
      if (!diff[DATA_W]) begin
        rem_d = diff[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b0};
      end
      step_d = step_q - SW'(1);
      if (step_q == SW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
    dz_q  <= dz_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? ('0 - quo_q) : quo_q;
  assign dz_o   = dz_q;

endmodule

/* rtl/iee_dp.sv */
// ----------------------------------------------------------------------------
// iee_dp : evaluator datapath
// Operand and operator stacks in RAM with cached tops, the reduction ALU,
// the divider, error flags and the result output register.
// ----------------------------------------------------------------------------
module iee_dp
  import iee_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = IEE_STACK_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  iee_cmd_t          cmd_i,
  output iee_sts_t          sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] out_value_o,
  output logic [STS_W-1:0]  out_status_o
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  // Operand stack
  logic [CW-1:0]     opnd_cnt_q, opnd_cnt_d;
  logic [DATA_W-1:0] opnd_top_q, opnd_top_d;
  logic              opnd_full, opnd_ge2, opnd_ne0;
  logic [CW-1:0]     opnd_base;
  logic              opnd_we;
  logic [AW-1:0]     opnd_waddr;
  logic [DATA_W-1:0] opnd_wdata;
  logic [DATA_W-1:0] opnd_rdata;
  logic [DATA_W-1:0] digit_val;

  // Operator stack
  logic [CW-1:0]     opr_cnt_q, opr_cnt_d;
  opc_e              opr_top_q, opr_top_d;
  logic              opr_full, opr_empty, opr_pop;
  logic              opr_we;
  logic [CW-1:0]     opr_rd_idx;
  logic [OPC_W-1:0]  opr_rdata;

  // Reduction
  opc_e              op_q;
  logic [DATA_W-1:0] x_q, y_q;
  logic [DATA_W-1:0] res_q;
  logic [DATA_W-1:0] alu;
  logic              div_start, div_done, div_dz;
  logic [DATA_W-1:0] div_quot;

  // Errors and output
  logic [1:0]        err_q, err_d;
  logic              ovf_evt;
  logic              out_valid_q;
  logic [DATA_W-1:0] out_value_q;
  logic [STS_W-1:0]  out_status_q;
  sts_e              sts_code;

  assign opnd_full = (opnd_cnt_q == CW'(STACK_DEPTH));
  assign opnd_ge2  = (opnd_cnt_q >= CW'(2));
  assign opnd_ne0  = (opnd_cnt_q != '0);
  assign opnd_base = opnd_ge2 ? (opnd_cnt_q - CW'(2)) : '0;
  assign digit_val = {{(DATA_W-4){1'b0}}, cmd_i.digit};

  assign opr_full   = (opr_cnt_q == CW'(STACK_DEPTH));
  assign opr_empty  = (opr_cnt_q == '0);
  assign opr_pop    = cmd_i.opr_pop || cmd_i.red_rd;
  assign opr_rd_idx = opr_cnt_q - CW'(2);

  // Operand RAM ports: reduction result lands at the base of the popped pair
  assign opnd_we    = (cmd_i.opnd_push && !opnd_full) || cmd_i.red_wb;
  assign opnd_waddr = cmd_i.red_wb ? opnd_base[AW-1:0] : opnd_cnt_q[AW-1:0];
  assign opnd_wdata = cmd_i.red_wb ? res_q : digit_val;

  iee_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_opnd_ram (
    .clk_i   (clk_i),
    .we_i    (opnd_we),
    .waddr_i (opnd_waddr),
    .wdata_i (opnd_wdata),
    .raddr_i (opnd_base[AW-1:0]),
    .rdata_o (opnd_rdata)
  );

  assign opr_we = cmd_i.opr_push && !opr_full;

  iee_ram #(
    .WIDTH (OPC_W),
    .DEPTH (STACK_DEPTH)
  ) u_opr_ram (
    .clk_i   (clk_i),
    .we_i    (opr_we),
    .waddr_i (opr_cnt_q[AW-1:0]),
    .wdata_i (cmd_i.opr_code),
    .raddr_i (opr_rd_idx[AW-1:0]),
    .rdata_o (opr_rdata)
  );

  // Stack counts and cached tops
  always_comb begin
    opnd_cnt_d = opnd_cnt_q;
    opnd_top_d = opnd_top_q;
    if (cmd_i.emit) begin
      opnd_cnt_d = '0;
    end else if (cmd_i.red_wb) begin
      opnd_cnt_d = opnd_base + CW'(1);
      opnd_top_d = res_q;
    end else if (cmd_i.opnd_push && !opnd_full) begin
      opnd_cnt_d = opnd_cnt_q + CW'(1);
      opnd_top_d = digit_val;
    end
  end

  always_comb begin
    opr_cnt_d = opr_cnt_q;
    opr_top_d = opr_top_q;
    if (cmd_i.emit) begin
      opr_cnt_d = '0;
    end else if (opr_we) begin
      opr_cnt_d = opr_cnt_q + CW'(1);
      opr_top_d = cmd_i.opr_code;
    end else if (opr_pop && !opr_empty) begin
      opr_cnt_d = opr_cnt_q - CW'(1);
    end
    if (cmd_i.top_ld) begin
      opr_top_d = opc_e'(opr_rdata);
    end
  end

  // Error flags: bit 0 divide by zero, bit 1 overflow
  assign ovf_evt = (cmd_i.opnd_push && opnd_full) || (cmd_i.opr_push && opr_full);

  always_comb begin
    err_d = err_q;
    if (cmd_i.emit) begin
      err_d = '0;
    end else begin
      err_d[1] = err_q[1] | ovf_evt;
      err_d[0] = err_q[0] | (div_done && div_dz);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opnd_cnt_q <= '0;
      opr_cnt_q  <= '0;
      err_q      <= '0;
    end else begin
      opnd_cnt_q <= opnd_cnt_d;
      opr_cnt_q  <= opr_cnt_d;
      err_q      <= err_d;
    end
  end

  // ALU for the non-dividing operators; an unclosed bracket reduces to 0
  always_comb begin
    case (op_q)
      OPC_ADD: alu = y_q + x_q;
      OPC_SUB: alu = y_q - x_q;
      OPC_MUL: alu = y_q * x_q;
      default: alu = '0;
    endcase
  end

  assign div_start = cmd_i.red_exec && (op_q == OPC_DIV);

  iee_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (y_q),
    .den_i   (x_q),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .dz_o    (div_dz)
  );

  // Payload registers of the stacks and the reduction
  always_ff @(posedge clk_i) begin
    opnd_top_q <= opnd_top_d;
    opr_top_q  <= opr_top_d;
    if (cmd_i.red_rd) begin
      op_q <= opr_top_q;
    end
    if (cmd_i.red_ld) begin
      x_q <= opnd_ne0 ? opnd_top_q : '0;
      y_q <= opnd_ge2 ? opnd_rdata : '0;
    end
    if (cmd_i.red_exec && (op_q != OPC_DIV)) begin
      res_q <= alu;
    end else if (div_done) begin
      res_q <= div_quot;
    end
  end

  // Result beat
  always_comb begin
    if (err_q[1]) begin
      sts_code = STS_OVERFLOW;
    end else if (err_q[0]) begin
      sts_code = STS_DIVZERO;
    end else begin
      sts_code = STS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_value_q  <= opnd_ne0 ? opnd_top_q : '0;
      out_status_q <= sts_code;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;

  // Status to the controller
  assign sts_o.opnd_ge2   = opnd_ge2;
  assign sts_o.opr_empty  = opr_empty;
  assign sts_o.opr_top    = opr_top_q;
  assign sts_o.red_is_div = (op_q == OPC_DIV);
  assign sts_o.div_done   = div_done;
  assign sts_o.out_full   = out_valid_q && !out_ready_i;

endmodule

/* rtl/iee_ctrl.sv */
// ----------------------------------------------------------------------------
// iee_ctrl : evaluator controller
// Takes characters, decides on pushes and reductions by precedence and
// sequences each reduction and the final emit through the datapath.
// ----------------------------------------------------------------------------
module iee_ctrl
  import iee_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] s_symbol_i,
  input  logic       s_last_i,
  input  iee_sts_t   sts_i,
  output iee_cmd_t   cmd_o
);

  ctrl_state_e state_q, state_d;
  logic [7:0]  sym_q;
  logic        last_q;
  logic        fin_q, fin_d;
  logic        once_q, once_d;
  logic        accept;
  chr_e        chr;
  opc_e        sym_opc;
  logic        red_go;
  logic        pop_go;
  ctrl_state_e after_char;

  assign s_ready_o = (state_q == S_IDLE);
  assign accept    = s_valid_i && s_ready_o;

  // Decode of the held character against the operator stack top
  always_comb begin
    chr     = classify(sym_q);
    red_go  = 1'b0;
    pop_go  = 1'b0;
    sym_opc = OPC_LPAR;
    case (chr)
      CHR_ADDSUB: begin
        sym_opc = (sym_q == CH_PLUS) ? OPC_ADD : OPC_SUB;
        red_go  = !sts_i.opr_empty && (sts_i.opr_top != OPC_LPAR) && sts_i.opnd_ge2;
      end
      CHR_MULDIV: begin
        sym_opc = (sym_q == CH_STAR) ? OPC_MUL : OPC_DIV;
        red_go  = !once_q && !sts_i.opr_empty &&
                  (sts_i.opr_top == OPC_MUL || sts_i.opr_top == OPC_DIV);
      end
      CHR_RPAR: begin
        red_go = !sts_i.opr_empty && (sts_i.opr_top != OPC_LPAR);
        pop_go = !sts_i.opr_empty && (sts_i.opr_top == OPC_LPAR);
      end
      default: begin
      end
    endcase
    after_char = last_q ? S_FINAL : S_IDLE;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (red_go) begin
          state_d = S_RED_RD;
        end else if (pop_go) begin
          state_d = S_POP_WAIT;
        end else begin
          state_d = after_char;
        end
      end
      S_RED_RD:   state_d = S_RED_LD;
      S_RED_LD:   state_d = S_RED_EXEC;
      S_RED_EXEC: state_d = sts_i.red_is_div ? S_RED_DIV : S_RED_WB;
      S_RED_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_RED_WB;
        end
      end
      S_RED_WB:   state_d = fin_q ? S_FINAL : S_DISPATCH;
      S_POP_WAIT: state_d = after_char;
      S_FINAL:    state_d = sts_i.opr_empty ? S_EMIT : S_RED_RD;
      S_EMIT: begin
        if (!sts_i.out_full) begin
          state_d = S_IDLE;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.opr_code = sym_opc;
    cmd_o.digit    = 4'(sym_q - CH_ZERO);
    unique case (state_q)
      S_DISPATCH: begin
        case (chr)
          CHR_DIGIT:  cmd_o.opnd_push = 1'b1;
          CHR_ADDSUB,
          CHR_MULDIV: cmd_o.opr_push  = !red_go;
          CHR_LPAR:   cmd_o.opr_push  = 1'b1;
          CHR_RPAR:   cmd_o.opr_pop   = !red_go && pop_go;
          default: begin
          end
        endcase
      end
      S_RED_RD:   cmd_o.red_rd = 1'b1;
      S_RED_LD: begin
        cmd_o.red_ld = 1'b1;
        cmd_o.top_ld = 1'b1;
      end
      S_RED_EXEC: cmd_o.red_exec = 1'b1;
      S_RED_WB:   cmd_o.red_wb   = 1'b1;
      S_POP_WAIT: cmd_o.top_ld   = 1'b1;
      S_EMIT:     cmd_o.emit     = !sts_i.out_full;
      default: begin
      end
    endcase
  end

  // Phase flags: final reduction running, a reduction already started for the held character
  always_comb begin
    fin_d  = fin_q;
    once_d = once_q;
    if (accept) begin
      fin_d  = 1'b0;
      once_d = 1'b0;
    end else begin
      if (state_d == S_FINAL) begin
        fin_d = 1'b1;
      end
      if (state_q == S_DISPATCH && red_go) begin
        once_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fin_q   <= 1'b0;
      once_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      once_q  <= once_d;
    end
  end

  // Held character
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sym_q  <= s_symbol_i;
      last_q <= s_last_i;
    end
  end

endmodule

/* rtl/infix_expression_evaluator_top.sv */
// ----------------------------------------------------------------------------
// A character without reductions goes from S_DISPATCH back to S_IDLE, a ')'
// that drops its '(' through S_POP_WAIT too. Each reduction runs S_RED_RD,
// S_RED_LD, S_RED_EXEC and S_RED_WB, a division also waits in S_RED_DIV on
// the shared divider (one quotient bit a cycle; a zero divisor ends at once).
// A final character runs the reductions left, then S_FINAL and S_EMIT, which
// waits while the previous beat is held. A new character is taken only in S_IDLE.
// Reset (rst_ni low, asynchronous) empties both stacks and clears errors.
// ----------------------------------------------------------------------------
// infix_expression_evaluator_top : two-stack infix expression evaluator
// Evaluates single-digit infix expressions with + - * / and brackets in
// 32-bit wrapping arithmetic, one result beat per expression.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_top
  import iee_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = IEE_STACK_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] symbol
  input  logic                  s_axis_tlast,   // last
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // [31:0] value, [33:32] status
);

  iee_cmd_t          cmd;
  iee_sts_t          sts;
  logic [DATA_W-1:0] out_value;
  logic [STS_W-1:0]  out_status;

  iee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_symbol_i (s_axis_tdata),
    .s_last_i   (s_axis_tlast),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  iee_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_value_o  (out_value),
    .out_status_o (out_status)
  );

  // Pack the result beat
  assign m_axis_tdata = {{(OUT_DATA_W-DATA_W-STS_W){1'b0}}, out_status, out_value};

  // At most one datapath action a cycle, the operator top load apart
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.opnd_push, cmd.opr_push, cmd.opr_pop, cmd.red_rd,
              cmd.red_ld, cmd.red_exec, cmd.red_wb, cmd.emit}))
    else $error("more than one datapath command in a cycle");

  // A character is held for processing, so ready drops after each beat
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while previous character in progress");

  // Operand fetch follows the operator pop
  a_red_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.red_rd |=> cmd.red_ld)
    else $error("reduction sequence broken");

  // An emit always shows up on the output
  a_emit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> m_axis_tvalid)
    else $error("emitted result not presented");

endmodule
